[src/nsd_pkg.sv]
package nsd_pkg;

  localparam int MAX_VARS   = 16;
  localparam int MAX_REFS   = 256;
  localparam int VALUE_BITS = 8;

  localparam int POS_W = $clog2(MAX_VARS);
  localparam int IDX_W = $clog2(MAX_REFS);
  localparam int CNT_W = $clog2(MAX_REFS + 1);

  // field widths of the ports
  localparam int NV_W     = 5;
  localparam int MAXV_W   = 8;
  localparam int ACT_W    = 2;
  localparam int VAL_W    = 8;
  localparam int BIDX_W   = 8;
  localparam int HAM_W    = 5;
  localparam int MAN_W    = 12;
  localparam int SCORE_W  = 20;
  localparam int WEIGHT_W = 16;

  // adder tree grouping in the distance pipeline
  localparam int GRP_LANES = 4;
  localparam int NUM_GRP   = MAX_VARS / GRP_LANES;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QELEM,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [NV_W-1:0]   nv;
    logic [MAXV_W-1:0] maxv;
  } cfg_t;

  typedef logic [MAX_VARS-1:0][VALUE_BITS-1:0] vec_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [IDX_W-1:0]   idx;
    logic [HAM_W-1:0]   ham;
    logic [MAN_W-1:0]   man;
    logic [SCORE_W-1:0] score;
  } dist_t;

endpackage

[src/nsd_front.sv]
module nsd_front import nsd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [ACT_W-1:0] action,
  input  logic [VAL_W-1:0] value,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_pop
);

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] head;
  logic [CMDQ_AW-1:0] tail;
  logic [CMDQ_CW-1:0] cnt;

  cmd_t cls;
  logic keep;
  logic enq;
  logic deq;

  // unused action code is taken and dropped
  always_comb begin
    cls.value = value[VALUE_BITS-1:0];
    cls.kind  = CMD_LOAD;
    keep      = 1'b1;
    case (action)
      ACT_LOAD:  cls.kind = CMD_LOAD;
      ACT_QUERY: cls.kind = CMD_QELEM;
      ACT_CLEAR: cls.kind = CMD_CLEAR;
      default:   keep = 1'b0;
    endcase
  end

  assign full      = (cnt == CMDQ_CW'(CMDQ_DEPTH));
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[head];
  assign enq       = push && !full && keep;
  assign deq       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (enq) tail <= tail + CMDQ_AW'(1);
      if (deq) head <= head + CMDQ_AW'(1);
      if (enq && !deq) cnt <= cnt + CMDQ_CW'(1);
      else if (!enq && deq) cnt <= cnt - CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) q[tail] <= cls;
  end

endmodule

[src/nsd_dist.sv]
module nsd_dist import nsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  tag_t                tag_in,
  input  vec_t                qv,
  input  vec_t                rv,
  input  logic [MAX_VARS-1:0] lane_en,
  input  logic [WEIGHT_W-1:0] weight,
  output dist_t               d
);

  tag_t t1, t2, t3;

  logic [MAX_VARS-1:0]                 ne_c, ne_r;
  logic [MAX_VARS-1:0][VALUE_BITS-1:0] ad_c, ad_r;
  logic [NUM_GRP-1:0][HAM_W-1:0]       gh_c, gh_r;
  logic [NUM_GRP-1:0][MAN_W-1:0]       gm_c, gm_r;
  logic [HAM_W-1:0]                    h_c, h_r;
  logic [MAN_W-1:0]                    m_c, m_r;
  logic [SCORE_W-1:0]                  s_c;

  // stage 1: per-lane difference
  always_comb begin
    for (int l = 0; l < MAX_VARS; l++) begin
      ne_c[l] = lane_en[l] && (qv[l] != rv[l]);
      if (!ne_c[l]) ad_c[l] = '0;
      else if (qv[l] > rv[l]) ad_c[l] = qv[l] - rv[l];
      else ad_c[l] = rv[l] - qv[l];
    end
  end

  // stage 2: partial sums per group of lanes
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      gh_c[g] = '0;
      gm_c[g] = '0;
      for (int k = 0; k < GRP_LANES; k++) begin
        gh_c[g] = gh_c[g] + HAM_W'(ne_r[g*GRP_LANES+k]);
        gm_c[g] = gm_c[g] + MAN_W'(ad_r[g*GRP_LANES+k]);
      end
    end
  end

  // stage 3: final sums
  always_comb begin
    h_c = '0;
    m_c = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      h_c = h_c + gh_r[g];
      m_c = m_c + gm_r[g];
    end
  end

  // stage 4: weighted score, 9*m as shift and add
  assign s_c = (SCORE_W'(weight) * SCORE_W'(h_r)) + (SCORE_W'(m_r) << 3) + SCORE_W'(m_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1      <= '0;
      t2      <= '0;
      t3      <= '0;
      d.valid <= 1'b0;
      d.last  <= 1'b0;
    end else begin
      t1      <= tag_in;
      t2      <= t1;
      t3      <= t2;
      d.valid <= t3.valid;
      d.last  <= t3.last;
      d.idx   <= t3.idx;
      d.ham   <= h_r;
      d.man   <= m_r;
      d.score <= s_c;
    end
  end

  always_ff @(posedge clk) begin
    ne_r    <= ne_c;
    ad_r    <= ad_c;
    gh_r    <= gh_c;
    gm_r    <= gm_c;
    h_r     <= h_c;
    m_r     <= m_c;
  end

endmodule

[src/nsd_back.sv]
module nsd_back import nsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output logic               found,
  output logic [BIDX_W-1:0]  best_index,
  output logic [HAM_W-1:0]   hamming,
  output logic [MAN_W-1:0]   manhattan,
  output logic [SCORE_W-1:0] score
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]    count;
  logic [POS_W-1:0]    load_pos;
  logic [POS_W-1:0]    qpos;
  logic [IDX_W-1:0]    scan_r;
  logic                scan_last;
  vec_t                qbuf;
  vec_t                rd_vec;
  tag_t                rd_tag;
  logic [WEIGHT_W-1:0] weight;
  logic [WEIGHT_W-1:0] prod;
  logic [MAX_VARS-1:0] lane_en;
  dist_t               d;

  logic               have;
  logic [IDX_W-1:0]   best_idx;
  logic [HAM_W-1:0]   best_h;
  logic [MAN_W-1:0]   best_m;
  logic [SCORE_W-1:0] best_s;
  logic               res_valid;
  logic               res_free;

  logic             wr_en;
  logic             is_load, is_qelem, is_clear;
  logic             load_done, q_done;

  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;
  assign is_load   = cmd_pop && (cmd.kind == CMD_LOAD);
  assign is_qelem  = cmd_pop && (cmd.kind == CMD_QELEM);
  assign is_clear  = cmd_pop && (cmd.kind == CMD_CLEAR);
  assign wr_en     = is_load && (count != CNT_W'(MAX_REFS));
  assign load_done = (NV_W'(load_pos) + NV_W'(1)) >= cfg.nv;
  assign q_done    = (NV_W'(qpos) + NV_W'(1)) >= cfg.nv;
  assign scan_last = (CNT_W'(scan_r) == count - CNT_W'(1));
  assign res_free  = !res_valid || pop;
  assign empty     = !res_valid;

  assign prod = WEIGHT_W'(cfg.nv) * WEIGHT_W'(cfg.maxv);

  always_comb begin
    for (int l = 0; l < MAX_VARS; l++) lane_en[l] = (NV_W'(l) < cfg.nv);
  end

  // one memory per lane; a vector is read across all lanes in the same cycle
  for (genvar l = 0; l < MAX_VARS; l++) begin : g_lane
    logic [VALUE_BITS-1:0] mem [MAX_REFS];
    always_ff @(posedge clk) begin
      if (wr_en && (load_pos == POS_W'(l))) mem[count[IDX_W-1:0]] <= cmd.value;
      rd_vec[l] <= mem[scan_r];
    end
  end

  nsd_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (rd_tag),
    .qv      (qbuf),
    .rv      (rd_vec),
    .lane_en (lane_en),
    .weight  (weight),
    .d       (d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      load_pos  <= '0;
      qpos      <= '0;
      scan_r    <= '0;
      rd_tag    <= '0;
      have      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_SCAN) rd_tag <= '{valid: 1'b1, last: scan_last, idx: scan_r};
      else rd_tag <= '0;

      if (state == ST_DONE && res_free) res_valid <= 1'b1;
      else if (pop) res_valid <= 1'b0;

      if (d.valid && (!have || d.score < best_s)) have <= 1'b1;

      case (state)
        ST_IDLE: begin
          if (wr_en) begin
            if (load_done) begin
              load_pos <= '0;
              count    <= count + CNT_W'(1);
            end else begin
              load_pos <= load_pos + POS_W'(1);
            end
          end
          if (is_clear) begin
            count    <= '0;
            load_pos <= '0;
          end
          if (is_qelem) begin
            if (q_done) begin
              qpos   <= '0;
              scan_r <= '0;
              have   <= 1'b0;
              state  <= (count == '0) ? ST_DONE : ST_SCAN;
            end else begin
              qpos <= qpos + POS_W'(1);
            end
          end
        end
        ST_SCAN: begin
          scan_r <= scan_r + IDX_W'(1);
          if (scan_last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (d.valid && d.last) state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_qelem) qbuf[qpos] <= cmd.value;
    if (is_qelem && q_done) begin
      weight   <= (prod << 3) + (prod << 1);
      best_idx <= '0;
      best_h   <= '0;
      best_m   <= '0;
      best_s   <= '0;
    end else if (d.valid && (!have || d.score < best_s)) begin
      best_idx <= d.idx;
      best_h   <= d.ham;
      best_m   <= d.man;
      best_s   <= d.score;
    end
    if (state == ST_DONE && res_free) begin
      found      <= have;
      best_index <= BIDX_W'(best_idx);
      hamming    <= best_h;
      manhattan  <= best_m;
      score      <= best_s;
    end
  end

endmodule

[src/nearest_solution_distance.sv]
// Nearest-neighbor search over up to 256 stored reference vectors of up to 16 8-bit
// elements, with cost 10*num_vars*(largest domain value)*hamming + 9*manhattan (ties
// keep the lowest index). Requests enter a 4-deep command queue; full only rises when
// it fills. A reference load, a clear, or a query element that does not finish its
// vector is handled without leaving the idle state. The element that completes a
// query starts a scan: the 16 lane memories deliver one whole reference vector per
// cycle into a 4-stage distance pipeline, then the best match is posted to a
// one-entry result register. An empty store skips the scan and gives a result
// with found low. The back end keeps taking loads while a result waits, but holds a
// second finished search until the first result is popped.
module nearest_solution_distance import nsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [ACT_W-1:0]   action,
  input  logic [VAL_W-1:0]   value,
  output logic               empty,
  input  logic               pop,
  output logic               found,
  output logic [BIDX_W-1:0]  best_index,
  output logic [HAM_W-1:0]   hamming,
  output logic [MAN_W-1:0]   manhattan,
  output logic [SCORE_W-1:0] score
);

  localparam logic REG_NUM_VARS = 1'b0;
  localparam logic REG_DOM_MAX  = 1'b1;

  logic [NV_W-1:0]   num_vars;
  logic [MAXV_W-1:0] dom_max;
  logic              reg_wr;
  cfg_t              cfg;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars <= NV_W'(16);
      dom_max  <= MAXV_W'(255);
    end else if (reg_wr) begin
      case (paddr[2])
        REG_NUM_VARS: num_vars <= pwdata[NV_W-1:0];
        REG_DOM_MAX:  dom_max  <= pwdata[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_VARS: prdata = 32'(num_vars);
      REG_DOM_MAX:  prdata = 32'(dom_max);
      default:      prdata = '0;
    endcase
  end

  // clamp num_vars to 1..MAX_VARS, a zero domain max reads as one
  always_comb begin
    if (num_vars == '0) cfg.nv = NV_W'(1);
    else if (num_vars > NV_W'(MAX_VARS)) cfg.nv = NV_W'(MAX_VARS);
    else cfg.nv = num_vars;
    cfg.maxv = (dom_max == '0) ? MAXV_W'(1) : dom_max;
  end

  nsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  nsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .found      (found),
    .best_index (best_index),
    .hamming    (hamming),
    .manhattan  (manhattan),
    .score      (score)
  );

  // a result leaves only when popped
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    $rose(empty) |-> $past(pop))
    else $error("result dropped without a pop");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (best_index == '0 && hamming == '0 && manhattan == '0
                            && score == '0))
    else $error("empty-store result carries nonzero fields");

  a_ham_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (hamming <= HAM_W'(MAX_VARS)))
    else $error("hamming count exceeds vector length");

  a_exact_match: assert property (@(posedge clk) disable iff (rst)
    (!empty && hamming == '0) |-> (manhattan == '0))
    else $error("manhattan nonzero on exact match");

endmodule

[dv/nearest_solution_distance_tb.sv]
`timescale 1ns / 1ps

module nearest_solution_distance_tb;
  import nsd_pkg::*;

  localparam int LIMIT  = 400000;
  // a search walks every stored vector, plus pipeline and queue slack
  localparam int SETTLE = 300;

  localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;
  localparam logic [2:0]       REG_NUM_VARS = 3'd0;
  localparam logic [2:0]       REG_DOM_MAX  = 3'd4;

  typedef struct {
    logic [ACT_W-1:0] act;
    logic [VAL_W-1:0] val;
  } request_t;

  typedef struct {
    logic               found;
    logic [BIDX_W-1:0]  idx;
    logic [HAM_W-1:0]   ham;
    logic [MAN_W-1:0]   man;
    logic [SCORE_W-1:0] score;
  } match_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [2:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               push    = 1'b0;
  logic               full;
  logic [ACT_W-1:0]   action  = ACT_LOAD;
  logic [VAL_W-1:0]   value   = '0;
  logic               empty;
  logic               pop     = 1'b0;
  logic               found;
  logic [BIDX_W-1:0]  best_index;
  logic [HAM_W-1:0]   hamming;
  logic [MAN_W-1:0]   manhattan;
  logic [SCORE_W-1:0] score;

  nearest_solution_distance dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .action     (action),
    .value      (value),
    .empty      (empty),
    .pop        (pop),
    .found      (found),
    .best_index (best_index),
    .hamming    (hamming),
    .manhattan  (manhattan),
    .score      (score)
  );

  always #6 clk = ~clk;

  // shadow of the block's configuration and store
  logic [NV_W-1:0]   cfg_nv   = 5'd16;
  logic [MAXV_W-1:0] cfg_maxv = 8'd255;
  logic [VAL_W-1:0]  ref_mem [MAX_REFS][MAX_VARS];
  logic [VAL_W-1:0]  qry_buf [MAX_VARS];
  int unsigned       ref_cnt  = 0;
  int unsigned       load_pos = 0;
  int unsigned       qry_pos  = 0;

  match_t   match_q[$];
  request_t req_q[$];
  vec_t     gen_refs[$];
  request_t next_req;

  int errors       = 0;
  int cycles       = 0;
  int n_req        = 0;
  int n_checked    = 0;
  int n_empty      = 0;
  int n_dropped    = 0;
  int tx_idle_pct  = 24;
  int rx_stall_pct = 79;
  bit took_req     = 1'b0;

  function automatic int unsigned vars_now();
    int unsigned n;
    n = cfg_nv;
    if (n == 0) n = 1;
    if (n > MAX_VARS) n = MAX_VARS;
    return n;
  endfunction

  function automatic int unsigned maxv_now();
    return (cfg_maxv == 0) ? 1 : cfg_maxv;
  endfunction

  function automatic match_t nearest_match();
    match_t          best;
    longint unsigned weight, sc, best_sc;
    int unsigned     h, m, a, b, nv, r, i;
    bit              have;
    nv = vars_now();
    weight = 10 * nv * maxv_now();
    best.found = 1'b0;
    best.idx = '0;
    best.ham = '0;
    best.man = '0;
    best.score = '0;
    have = 1'b0;
    best_sc = 0;
    for (r = 0; r < ref_cnt; r++) begin
      h = 0;
      m = 0;
      for (i = 0; i < nv; i++) begin
        a = qry_buf[i];
        b = ref_mem[r][i];
        if (a != b) begin
          h++;
          m += (a > b) ? a - b : b - a;
        end
      end
      sc = weight * h + 9 * m;
      // strict compare: earliest vector wins a tie
      if (!have || sc < best_sc) begin
        have = 1'b1;
        best_sc = sc;
        best.found = 1'b1;
        best.idx = BIDX_W'(r);
        best.ham = HAM_W'(h);
        best.man = MAN_W'(m);
        best.score = SCORE_W'(sc);
      end
    end
    return best;
  endfunction

  function automatic void apply_request(logic [ACT_W-1:0] act, logic [VAL_W-1:0] val);
    int unsigned pos;
    match_t      res;
    case (act)
      ACT_CLEAR: begin
        ref_cnt = 0;
        load_pos = 0;
      end
      ACT_LOAD: begin
        if (ref_cnt < MAX_REFS) begin
          pos = load_pos % MAX_VARS;
          ref_mem[ref_cnt][pos] = val;
          load_pos = pos + 1;
          if (load_pos >= vars_now()) begin
            load_pos = 0;
            ref_cnt++;
          end
        end else begin
          n_dropped++;
        end
      end
      ACT_QUERY: begin
        pos = qry_pos % MAX_VARS;
        qry_buf[pos] = val;
        qry_pos = pos + 1;
        if (qry_pos >= vars_now()) begin
          qry_pos = 0;
          res = nearest_match();
          if (!res.found) n_empty++;
          match_q.insert(match_q.size(), res);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("cycle %0d: mismatch: %s", cycles, what);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, match_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    match_t want;
    took_req = !rst && push && !full;
    if (took_req) begin
      n_req++;
      apply_request(action, value);
    end
    if (!rst && pop && !empty) begin
      n_checked++;
      if (match_q.size() == 0) begin
        report_mismatch("result with no search pending");
      end else begin
        want = match_q.pop_front();
        check_field("found", found, want.found);
        check_field("best_index", best_index, want.idx);
        check_field("hamming", hamming, want.ham);
        check_field("manhattan", manhattan, want.man);
        check_field("score", score, want.score);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!push || took_req) begin
        if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_req = req_q.pop_front();
          push <= 1'b1;
          action <= next_req.act;
          value <= next_req.val;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    logic [31:0] mask;
    mask = (addr == REG_NUM_VARS) ? 32'h1f : 32'hff;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == REG_NUM_VARS) cfg_nv = data[NV_W-1:0];
    else cfg_maxv = data[MAXV_W-1:0];
    // read back through the same port
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (data & mask))
      report_mismatch($sformatf("register %0d read %0h wrote %0h", addr, prdata, data));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_request(logic [ACT_W-1:0] act, logic [VAL_W-1:0] val);
    request_t rq;
    rq.act = act;
    rq.val = val;
    req_q.insert(req_q.size(), rq);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return VAL_W'($urandom_range(maxv_now()));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // whole vector, often a copy or a near copy of a recent reference
  task automatic add_vector(bit is_query);
    vec_t        v;
    int unsigned n, i, mode;
    n = vars_now();
    mode = $urandom_range(3);
    if (gen_refs.size() != 0 && mode != 0) begin
      v = gen_refs[$urandom_range(gen_refs.size() - 1)];
      if (mode != 1) begin
        for (i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0) begin
            if ($urandom_range(1) != 0) v[i] = v[i] + VAL_W'($urandom_range(4)) - VAL_W'(2);
            else v[i] = pick_value();
          end
        end
      end
    end else begin
      for (i = 0; i < MAX_VARS; i++) v[i] = pick_value();
    end
    for (i = 0; i < n; i++) add_request(is_query ? ACT_QUERY : ACT_LOAD, v[i]);
    if (!is_query) begin
      gen_refs.insert(gen_refs.size(), v);
      if (gen_refs.size() > 32) void'(gen_refs.pop_front());
    end
  endtask

  task automatic drain();
    while (req_q.size() != 0 || push || match_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic [NV_W-1:0] nv, logic [MAXV_W-1:0] maxv);
    int unsigned new_vars, i;
    logic [31:0] data;
    new_vars = (nv == 0) ? 1 : (nv > MAX_VARS) ? MAX_VARS : nv;
    if (new_vars > vars_now()) begin
      // longer vectors would reach elements that were never loaded
      if (qry_pos != 0)
        for (i = qry_pos; i < vars_now(); i++) add_request(ACT_QUERY, pick_value());
      add_request(ACT_CLEAR, pick_value());
      gen_refs.delete();
      drain();
    end
    data = $urandom;
    data[NV_W-1:0] = nv;
    cfg_write(REG_NUM_VARS, data);
    data = $urandom;
    data[MAXV_W-1:0] = maxv;
    cfg_write(REG_DOM_MAX, data);
  endtask

  task automatic run_phase(logic [NV_W-1:0] nv, logic [MAXV_W-1:0] maxv, int unsigned n_items);
    int unsigned target;
    set_config(nv, maxv);
    target = req_q.size() + n_items;
    while (req_q.size() < target) begin
      if ($urandom_range(3) != 0) add_vector($urandom_range(4) < 2);
      else add_request(ACT_W'($urandom_range(3)), VAL_W'($urandom));
    end
    drain();
  endtask

  task automatic run_store_full();
    int unsigned k;
    add_request(ACT_CLEAR, '0);
    drain();
    set_config(5'd0, 8'd0);
    for (k = 0; k < 260; k++) begin
      add_request(ACT_LOAD, VAL_W'($urandom));
      if (k % 45 == 44) add_request(ACT_QUERY, pick_value());
    end
    repeat (3) add_request(ACT_QUERY, VAL_W'($urandom));
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 24;
    rx_stall_pct = 79;
    set_config(5'd3, 8'd255);
    // search on an empty store
    add_request(ACT_QUERY, 8'h00);
    add_request(ACT_QUERY, 8'hff);
    add_request(ACT_QUERY, 8'h5a);
    // extremes, then a duplicate of the first vector: the tie keeps index 0
    add_request(ACT_LOAD, 8'h00);
    add_request(ACT_LOAD, 8'hff);
    add_request(ACT_LOAD, 8'h80);
    add_request(ACT_LOAD, 8'hff);
    add_request(ACT_LOAD, 8'h00);
    add_request(ACT_LOAD, 8'h07);
    add_request(ACT_LOAD, 8'h00);
    add_request(ACT_LOAD, 8'hff);
    add_request(ACT_LOAD, 8'h80);
    add_request(ACT_QUERY, 8'h00);
    add_request(ACT_QUERY, 8'hff);
    add_request(ACT_QUERY, 8'h80);
    add_request(ACT_QUERY, 8'hff);
    add_request(ACT_QUERY, 8'hff);
    add_request(ACT_QUERY, 8'hff);
    add_request(ACT_UNUSED, 8'hff);
    add_request(ACT_CLEAR, 8'h00);
    add_request(ACT_QUERY, 8'h11);
    add_request(ACT_QUERY, 8'h11);
    add_request(ACT_QUERY, 8'h11);
    drain();

    run_phase(5'd16, 8'd255, 32);
    run_phase(5'd4, 8'd7, 20);
    run_phase(5'd1, 8'd1, 10);

    tx_idle_pct = 79;
    rx_stall_pct = 24;
    run_store_full();
    run_phase(5'd31, 8'd200, 24);
    run_phase(5'd2, 8'd255, 15);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_phase(NV_W'($urandom_range(1, MAX_VARS)), MAXV_W'($urandom_range(1, 255)), 15);
    run_phase(NV_W'($urandom_range(1, MAX_VARS)), MAXV_W'($urandom_range(1, 255)), 15);
    run_phase(5'd16, 8'd1, 16);
    run_phase(5'd5, 8'd0, 10);

    $display("covered %0d requests and %0d search results, %0d of them on an empty store",
             n_req, n_checked, n_empty);
    $display("store filled to capacity with %0d loads dropped; %0d mismatches",
             n_dropped, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
